@@ design/class_pair_transition_counter_defines.svh @@
// Assertion macros shared by the class pair transition counter.
`ifndef CLASS_PAIR_TRANSITION_COUNTER_DEFINES_SVH
`define CLASS_PAIR_TRANSITION_COUNTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cptc_pkg.sv @@
// Shared constants, types and control structures of the class pair transition counter.
package cptc_pkg;

  localparam int ENTRIES    = 8;
  localparam int COORD_BITS = 8;
  localparam int COUNT_BITS = 16;

  localparam int ENTRY_IW  = $clog2(ENTRIES);
  localparam int KEY_W     = 4 * COORD_BITS;
  localparam int CLASS_W   = 3;
  localparam int CLASSES   = 1 << CLASS_W;
  localparam int CELLS     = CLASSES * CLASSES;
  localparam int CELL_W    = 2 * CLASS_W;

  localparam int OP_W        = 2;
  localparam int INDEX_W     = 3;
  localparam int PORT_COORD_W = 8;
  localparam int SEL_W       = 3;
  localparam int COUNT_OUT_W = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PRESENT = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic result_valid;
  } status_t;

endpackage

@@ design/cptc_ctrl.sv @@
// Controller state machine that sequences capture, lookup and commit of each word.
module cptc_ctrl
  import cptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !status.result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_next = item_valid ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    item_ready  = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = out_free;
        item_ready = out_free;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
    cmd.capture = item_valid && item_ready;
  end

endmodule

@@ design/cptc_datapath.sv @@
// Datapath: match table, pair count memory, role tracking and output register.
module cptc_datapath
  import cptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic [OP_W-1:0]         op,
  input  logic [INDEX_W-1:0]      entry_index,
  input  logic [PORT_COORD_W-1:0] coord_a,
  input  logic [PORT_COORD_W-1:0] coord_b,
  input  logic [PORT_COORD_W-1:0] coord_c,
  input  logic [PORT_COORD_W-1:0] coord_d,
  input  logic [CLASS_W-1:0]      class_id,
  input  logic [SEL_W-1:0]        row_sel,
  input  logic [SEL_W-1:0]        col_sel,
  input  logic                    result_ready,
  output logic                    result_valid,
  output logic                    matched,
  output logic [CLASS_W-1:0]      found_class,
  output logic                    was_future,
  output logic [COUNT_OUT_W-1:0]  count_value
);

  // Captured input word.
  op_t                cap_op;
  logic [INDEX_W-1:0] cap_index;
  logic [KEY_W-1:0]   cap_key;
  logic [CLASS_W-1:0] cap_class;
  logic [SEL_W-1:0]   cap_row;
  logic [SEL_W-1:0]   cap_col;

  // Match table.
  logic [KEY_W-1:0]   tbl_key   [ENTRIES];
  logic [CLASS_W-1:0] tbl_class [ENTRIES];
  logic [ENTRIES-1:0] tbl_valid;

  // Pair count memory; an entry never written reads as zero.
  logic [COUNT_BITS-1:0] cnt_mem [CELLS];
  logic [CELLS-1:0]      cnt_valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_valid;
  logic [CELL_W-1:0]     cnt_addr;

  logic               hit;
  logic [CLASS_W-1:0] hit_class;
  logic [CLASS_W-1:0] past_class;
  logic               future_turn;

  logic               lk_hit;
  logic [CLASS_W-1:0] lk_class;
  logic [CELL_W-1:0]  lk_addr;
  logic [COUNT_BITS-1:0] cur_count;
  logic               load_ok;
  logic               bump;

  assign status.result_valid = result_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op    <= op_t'(op);
      cap_index <= entry_index;
      cap_key   <= {COORD_BITS'(coord_d), COORD_BITS'(coord_c),
                    COORD_BITS'(coord_b), COORD_BITS'(coord_a)};
      cap_class <= class_id;
      cap_row   <= row_sel;
      cap_col   <= col_sel;
    end
  end

  // Lowest-numbered valid entry wins.
  always_comb begin
    lk_hit   = 1'b0;
    lk_class = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && (tbl_key[i] == cap_key)) begin
        lk_hit   = 1'b1;
        lk_class = tbl_class[i];
      end
    end
  end

  assign lk_addr = (cap_op == OP_PRESENT) ? {past_class, lk_class}
                                          : {CLASS_W'(cap_row), CLASS_W'(cap_col)};

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit       <= lk_hit;
      hit_class <= lk_class;
      cnt_addr  <= lk_addr;
      rd_valid  <= cnt_valid[lk_addr];
      rd_data   <= cnt_mem[lk_addr];
    end
  end

  assign cur_count = rd_valid ? rd_data : '0;
  assign load_ok   = (cap_op == OP_LOAD) && (int'(cap_index) < ENTRIES);
  assign bump      = cmd.commit && (cap_op == OP_PRESENT) && hit && future_turn
                     && (cur_count != COUNT_MAX);

  always_ff @(posedge clk) begin
    if (bump) begin
      cnt_mem[cnt_addr] <= cur_count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && load_ok) begin
      tbl_key[ENTRY_IW'(cap_index)]   <= cap_key;
      tbl_class[ENTRY_IW'(cap_index)] <= cap_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid   <= '0;
      cnt_valid   <= '0;
      past_class  <= '0;
      future_turn <= 1'b0;
    end else begin
      if (cmd.commit && load_ok) begin
        tbl_valid[ENTRY_IW'(cap_index)] <= 1'b1;
      end
      if (bump) begin
        cnt_valid[cnt_addr] <= 1'b1;
      end
      if (cmd.commit && (cap_op == OP_PRESENT)) begin
        if (hit && !future_turn) begin
          past_class <= hit_class;
        end
        future_turn <= !future_turn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      matched     <= (cap_op == OP_PRESENT) && hit;
      found_class <= ((cap_op == OP_PRESENT) && hit) ? hit_class : '0;
      was_future  <= (cap_op == OP_PRESENT) && future_turn;
      count_value <= (cap_op == OP_READ) ? COUNT_OUT_W'(cur_count) : '0;
    end
  end

endmodule

@@ design/class_pair_transition_counter.sv @@
// Top level of the class pair transition counter: controller, datapath and checks.
//
//   Channel  | Handshake                  | Word contents
//   ---------+----------------------------+------------------------------------------
//   item     | item_valid / item_ready    | op, entry_index, coord_a..d, class_id,
//            |                            | row_sel, col_sel
//   result   | result_valid / result_ready| matched, found_class, was_future,
//            |                            | count_value
//
// Every accepted word yields exactly one result word, after capture, a lookup with a
// registered count memory read, and a commit into the output register.
// While a word is in flight, the next is accepted no earlier than its commit: the commit cycle of
// one word is also the acceptance cycle of the next, and the single count memory port
// is read in the lookup cycle and written in the commit cycle.
// Reset (rst, synchronous, active high) empties the match table and marks every pair
// count as zero by clearing per-cell valid bits at once, so no clearing pass is needed.
// A result word held back by result_ready low stalls the commit, and with it intake.
module class_pair_transition_counter
  import cptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [INDEX_W-1:0]      entry_index,
  input  logic [PORT_COORD_W-1:0] coord_a,
  input  logic [PORT_COORD_W-1:0] coord_b,
  input  logic [PORT_COORD_W-1:0] coord_c,
  input  logic [PORT_COORD_W-1:0] coord_d,
  input  logic [CLASS_W-1:0]      class_id,
  input  logic [SEL_W-1:0]        row_sel,
  input  logic [SEL_W-1:0]        col_sel,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    matched,
  output logic [CLASS_W-1:0]      found_class,
  output logic                    was_future,
  output logic [COUNT_OUT_W-1:0]  count_value
);

`include "class_pair_transition_counter_defines.svh"

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all state of the matching and counting lives in
  // the datapath.
  cptc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the match table, the pair count memory with its valid bits,
  // the past class and role toggle, and the output register.
  cptc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (op),
    .entry_index  (entry_index),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .coord_d      (coord_d),
    .class_id     (class_id),
    .row_sel      (row_sel),
    .col_sel      (col_sel),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .matched      (matched),
    .found_class  (found_class),
    .was_future   (was_future),
    .count_value  (count_value)
  );

  // An accepted word is always looked up in the following cycle.
  `CPTC_ASSERT_NEXT(a_accept_then_lookup, item_valid && item_ready, cmd.lookup, "accepted word was not looked up")

  // A result word only appears as the product of a commit.
  `CPTC_ASSERT_SAME(a_result_from_commit, $rose(result_valid), $past(cmd.commit), "result word without commit")

  // A held result word is never overwritten by a commit.
  `CPTC_ASSERT_SAME(a_no_overwrite, result_valid && !result_ready, !cmd.commit, "commit over a held result word")

endmodule

@@ verif/class_pair_transition_checker.sv @@
// Checker for the class pair transition counter: watches both channels, predicts results, compares.
module class_pair_transition_checker
  import cptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic                    item_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [INDEX_W-1:0]      entry_index,
  input  logic [PORT_COORD_W-1:0] coord_a,
  input  logic [PORT_COORD_W-1:0] coord_b,
  input  logic [PORT_COORD_W-1:0] coord_c,
  input  logic [PORT_COORD_W-1:0] coord_d,
  input  logic [CLASS_W-1:0]      class_id,
  input  logic [SEL_W-1:0]        row_sel,
  input  logic [SEL_W-1:0]        col_sel,
  input  logic                    result_valid,
  input  logic                    result_ready,
  input  logic                    matched,
  input  logic [CLASS_W-1:0]      found_class,
  input  logic                    was_future,
  input  logic [COUNT_OUT_W-1:0]  count_value,
  output int                      mismatches,
  output int                      outstanding
);

  // Only the first lines are printed so that a broken build cannot flood the log.
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic                   matched;
    logic [CLASS_W-1:0]     found_class;
    logic                   was_future;
    logic [COUNT_OUT_W-1:0] count_value;
  } outcome_t;

  logic [KEY_W-1:0]      slot_key   [ENTRIES];
  logic [CLASS_W-1:0]    slot_class [ENTRIES];
  logic                  slot_live  [ENTRIES];
  logic [COUNT_BITS-1:0] pair_tally [CELLS];
  logic                  role_future;
  logic [CLASS_W-1:0]    prior_class;
  outcome_t              due_outcomes [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch: %s got %0d wanted %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Applies the accepted word to the private copy of the block state and gives its result.
  task automatic advance_table(output outcome_t res);
    logic [KEY_W-1:0]  key;
    logic [CELL_W-1:0] pair_idx;
    logic              hit;
    res = '0;
    hit = 1'b0;
    key = {coord_d[COORD_BITS-1:0], coord_c[COORD_BITS-1:0],
           coord_b[COORD_BITS-1:0], coord_a[COORD_BITS-1:0]};
    case (op)
      OP_LOAD: begin
        if (int'(entry_index) < ENTRIES) begin
          slot_key[entry_index]   = key;
          slot_class[entry_index] = class_id;
          slot_live[entry_index]  = 1'b1;
        end
      end
      OP_PRESENT: begin
        // The lowest-numbered live slot wins when several hold the same key.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && slot_live[i] && slot_key[i] == key) begin
            hit = 1'b1;
            res.found_class = slot_class[i];
          end
        end
        res.matched    = hit;
        res.was_future = role_future;
        if (hit) begin
          if (role_future) begin
            pair_idx = {prior_class, res.found_class};
            if (pair_tally[pair_idx] != COUNT_MAX)
              pair_tally[pair_idx] = pair_tally[pair_idx] + COUNT_BITS'(1);
          end else begin
            prior_class = res.found_class;
          end
        end
        role_future = !role_future;
      end
      OP_READ: begin
        res.count_value = COUNT_OUT_W'(pair_tally[{row_sel, col_sel}]);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_class[i] = '0;
        slot_live[i]  = 1'b0;
      end
      for (int i = 0; i < CELLS; i++)
        pair_tally[i] = '0;
      role_future = 1'b0;
      prior_class = '0;
      due_outcomes.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_outcomes.size() == 0) begin
          report_mismatch("result word with none outstanding", 1, 0);
        end else begin
          want = due_outcomes.pop_front();
          if (matched !== want.matched)
            report_mismatch("matched", matched, want.matched);
          if (found_class !== want.found_class)
            report_mismatch("found_class", found_class, want.found_class);
          if (was_future !== want.was_future)
            report_mismatch("was_future", was_future, want.was_future);
          if (count_value !== want.count_value)
            report_mismatch("count_value", count_value, want.count_value);
        end
      end
      if (item_valid && item_ready) begin
        advance_table(want);
        due_outcomes.push_back(want);
      end
    end
    outstanding = due_outcomes.size();
  end

endmodule

@@ verif/class_pair_transition_counter_tb.sv @@
// Testbench top for the class pair transition counter: stimulus, handshakes and verdict.
module class_pair_transition_counter_tb;
  import cptc_pkg::*;

  // The port allows a fourth opcode; the block must treat it as a no-op with a zero result.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 60;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // Random words per idling phase; four phases give roughly the wanted total.
  localparam int PHASE_WORDS = 107;

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  logic [OP_W-1:0]         op;
  logic [INDEX_W-1:0]      entry_index;
  logic [PORT_COORD_W-1:0] coord_a;
  logic [PORT_COORD_W-1:0] coord_b;
  logic [PORT_COORD_W-1:0] coord_c;
  logic [PORT_COORD_W-1:0] coord_d;
  logic [CLASS_W-1:0]      class_id;
  logic [SEL_W-1:0]        row_sel;
  logic [SEL_W-1:0]        col_sel;
  logic                    result_valid;
  logic                    result_ready;
  logic                    matched;
  logic [CLASS_W-1:0]      found_class;
  logic                    was_future;
  logic [COUNT_OUT_W-1:0]  count_value;

  int fail_count;
  int pending;

  // Idling controls. Each is written by the main stimulus process only.
  int send_idle_pct;
  int stall_pct;
  int hold_asks;

  // Keys that the stimulus has loaded, so that most presented vectors can hit the table.
  logic [KEY_W-1:0] loaded_key [ENTRIES];
  bit               loaded     [ENTRIES];

  int quiet;

  class_pair_transition_counter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .entry_index  (entry_index),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .coord_d      (coord_d),
    .class_id     (class_id),
    .row_sel      (row_sel),
    .col_sel      (col_sel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .matched      (matched),
    .found_class  (found_class),
    .was_future   (was_future),
    .count_value  (count_value)
  );

  class_pair_transition_checker pair_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .entry_index  (entry_index),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .coord_d      (coord_d),
    .class_id     (class_id),
    .row_sel      (row_sel),
    .col_sel      (col_sel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .matched      (matched),
    .found_class  (found_class),
    .was_future   (was_future),
    .count_value  (count_value),
    .mismatches   (fail_count),
    .outstanding  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver. It stalls at random according to stall_pct, and whenever the stimulus
  // asks for a hold-off it keeps ready low until a counter loaded from HOLD_CYCLES runs
  // out, so that the block backs up while the sender carries on offering words.
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left    = 0;
    holds_done   = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offers one word. It is entered at a falling edge and returns at the falling edge
  // after acceptance, leaving valid high so that a following word goes out back to back
  // unless an idle gap is drawn. Valid is only ever assigned once per time step.
  task automatic offer(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] idx,
                       input logic [KEY_W-1:0] key, input logic [CLASS_W-1:0] cls,
                       input logic [SEL_W-1:0] r, input logic [SEL_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    op          <= o;
    entry_index <= idx;
    coord_a     <= key[7:0];
    coord_b     <= key[15:8];
    coord_c     <= key[23:16];
    coord_d     <= key[31:24];
    class_id    <= cls;
    row_sel     <= r;
    col_sel     <= c;
    if (o == OP_LOAD) begin
      loaded[idx]     = 1'b1;
      loaded_key[idx] = key;
    end
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // The fields a given opcode does not use are filled at random, since the block
  // must ignore them.
  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [KEY_W-1:0] key,
                            input logic [CLASS_W-1:0] cls);
    offer(OP_LOAD, idx, key, cls, SEL_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic present(input logic [KEY_W-1:0] key);
    offer(OP_PRESENT, INDEX_W'($urandom), key, CLASS_W'($urandom),
          SEL_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic read_count(input logic [SEL_W-1:0] r, input logic [SEL_W-1:0] c);
    offer(OP_READ, INDEX_W'($urandom), KEY_W'($urandom), CLASS_W'($urandom), r, c);
  endtask

  // Sender pause: valid goes low and nothing more is offered until every result
  // word owed by the block has been taken.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One random word. Presents dominate, and most of them reuse a loaded key so that
  // the past/future pairing actually lands in the count matrix; a few carry a single
  // flipped bit to probe near misses. Loads sometimes copy another slot's key so that
  // duplicate entries appear and the lowest slot has to win.
  task automatic random_word;
    int               pick;
    int               k;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, ENTRIES - 1);
    key  = $urandom;
    if (pick < 15) begin
      if (loaded[k] && $urandom_range(0, 3) == 0)
        key = loaded_key[k];
      else if ($urandom_range(0, 9) == 0)
        key = $urandom_range(0, 1) ? '1 : '0;
      load_entry(INDEX_W'($urandom), key, CLASS_W'($urandom));
    end else if (pick < 70) begin
      if (loaded[k] && $urandom_range(0, 9) < 8) begin
        key = loaded_key[k];
        if ($urandom_range(0, 9) == 0)
          key = key ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      end
      present(key);
    end else if (pick < 95) begin
      read_count(SEL_W'($urandom), SEL_W'($urandom));
    end else begin
      offer(OP_SPARE, INDEX_W'($urandom), key, CLASS_W'($urandom),
            SEL_W'($urandom), SEL_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int idle_mode [4];
    int stall_mode [4];

    // Every block input is known from time zero.
    rst           = 1'b1;
    item_valid    = 1'b0;
    op            = OP_LOAD;
    entry_index   = '0;
    coord_a       = '0;
    coord_b       = '0;
    coord_c       = '0;
    coord_d       = '0;
    class_id      = '0;
    row_sel       = '0;
    col_sel       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asks     = 0;
    quiet         = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      loaded[i]     = 1'b0;
      loaded_key[i] = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words. Before anything is loaded a read gives zero, the spare opcode
    // gives zero, and presents miss while still alternating past and future.
    read_count('0, '0);
    offer(OP_SPARE, '1, '1, '1, '1, '1);
    present(32'h04030201);
    present('1);
    // Extremes of the coordinates and classes, plus a duplicate of slot 3 in slot 6
    // with a different class: slot 3 must win.
    load_entry(3'd0, '0, 3'd0);
    load_entry(3'd7, '1, 3'd7);
    load_entry(3'd3, 32'hF00FAA55, 3'd5);
    load_entry(3'd6, 32'hF00FAA55, 3'd1);
    present('0);             // past, class 0
    present('1);             // future, bumps (0,7)
    present(32'hF00FAA55);   // past, class 5 rather than 1
    present(32'h04030201);   // future, misses, counts untouched
    present(32'h09090909);   // past, misses, remembered class stays 5
    present('1);             // future, bumps (5,7)
    read_count(3'd0, 3'd7);
    read_count(3'd5, 3'd7);
    read_count(3'd7, 3'd7);
    read_count(3'd7, 3'd0);
    // Overwriting slot 7 takes the old key out of the table.
    load_entry(3'd7, 32'h01800180, 3'd3);
    present('1);             // past, now misses
    present(32'h01800180);   // future, bumps (5,3)
    read_count(3'd5, 3'd3);
    offer(OP_SPARE, '0, '0, '0, '0, '0);
    drain();

    // Random words in four idling regimes: none, a sluggish sender, a sluggish
    // receiver, and light idling on both sides. Each phase ends with a full drain.
    idle_mode  = '{0, 73, 0, 13};
    stall_mode = '{0, 0, 73, 13};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mode[p];
      stall_pct     = stall_mode[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Part way through the free-running phase the receiver holds off for a long
        // stretch while words keep coming, so the block fills and drops item_ready.
        if (p == 0 && n == PHASE_WORDS / 3)
          hold_asks++;
        random_word();
      end
      drain();
    end

    // Let any stray result word show up before the verdict.
    stall_pct = 0;
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
